// ===== rtl/mtv_pkg.sv =====
// Shared widths, register codes and payload types for the move-to-velocity block.
package mtv_pkg;

	localparam int POS_W      = 15;
	localparam int ENC_W      = 16;
	localparam int SPD_W      = 7;
	localparam int TOL_W      = 10;
	localparam int DRV_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;

	// error is target minus encoder: needs one more bit than the encoder, two are given
	localparam int ERR_W  = ENC_W + 2;
	localparam int MAG_W  = 16;
	localparam int SQ_W   = 2 * MAG_W + 1;
	localparam int RAD_W  = SQ_W + 1;
	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W  = ROOT_W + 3;
	localparam int NUM_W  = SPD_W + MAG_W;
	localparam int QUO_W  = SPD_W;

	localparam int SQRT_PER_STAGE = 2;
	localparam int SQRT_STAGES    = (ROOT_W + SQRT_PER_STAGE - 1) / SQRT_PER_STAGE;
	localparam int DIV_PER_STAGE  = 2;
	localparam int DIV_STAGES     = (QUO_W + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

	localparam logic [SPD_W-1:0] SPEED_MAX = 7'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_LIMIT   = 2'd0,
		REG_Y_LIMIT   = 2'd1,
		REG_TOLERANCE = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [POS_W-1:0] x_limit;
		logic [POS_W-1:0] y_limit;
		logic [TOL_W-1:0] tolerance;
	} cfg_t;

	typedef struct packed {
		logic [POS_W-1:0]        target_x;
		logic [POS_W-1:0]        target_y;
		logic [SPD_W-1:0]        move_speed;
		logic signed [ENC_W-1:0] enc_x;
		logic signed [ENC_W-1:0] enc_y;
	} in_t;

	typedef struct packed {
		logic signed [DRV_W-1:0] x_drive;
		logic signed [DRV_W-1:0] y_drive;
		logic                    arrived;
	} out_t;

	typedef struct packed {
		logic neg_x;
		logic neg_y;
		logic x_hi;
		logic x_lo;
		logic y_hi;
		logic y_lo;
		logic arrived;
	} flags_t;

	// front end to square root
	typedef struct packed {
		logic [RAD_W-1:0] rad;
		logic [NUM_W-1:0] nx;
		logic [NUM_W-1:0] ny;
		flags_t           flags;
	} sq_t;

	// square root to divider
	typedef struct packed {
		logic [ROOT_W-1:0] norm;
		logic [NUM_W-1:0]  nx;
		logic [NUM_W-1:0]  ny;
		flags_t            flags;
	} dv_t;

	// divider to drive stage
	typedef struct packed {
		logic [QUO_W-1:0] qx;
		logic [QUO_W-1:0] qy;
		flags_t           flags;
	} dq_t;

endpackage

// ===== rtl/mtv_front.sv =====
// Front end: axis errors, arrival test, limit flags, squares and speed products.
module mtv_front import mtv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic in_valid,
	output logic in_stall,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_stall,
	output sq_t  out_data
);

	typedef struct packed {
		logic [MAG_W-1:0] ax;
		logic [MAG_W-1:0] ay;
		logic [SPD_W-1:0] spd;
		flags_t           flags;
	} f1_t;

	typedef struct packed {
		logic [2*MAG_W-1:0] sqx;
		logic [2*MAG_W-1:0] sqy;
		logic [NUM_W-1:0]   nx;
		logic [NUM_W-1:0]   ny;
		flags_t             flags;
	} f2_t;

	f1_t  f1_d, f1_s1;
	f2_t  f2_d, f2_s2;
	sq_t  f3_d, f3_s3;
	logic vld_s1, vld_s2, vld_s3;
	logic adv1, adv2, adv3;

	logic [ERR_W-1:0] dx, dy, ax_full, ay_full;

	// let a bubble close up even while the far end is stalled
	assign adv3     = !vld_s3 || !out_stall;
	assign adv2     = !vld_s2 || adv3;
	assign adv1     = !vld_s1 || adv2;
	assign in_stall = !adv1;

	always_comb begin
		dx = {{(ERR_W-POS_W){1'b0}}, in_data.target_x}
			- {{(ERR_W-ENC_W){in_data.enc_x[ENC_W-1]}}, in_data.enc_x};
		dy = {{(ERR_W-POS_W){1'b0}}, in_data.target_y}
			- {{(ERR_W-ENC_W){in_data.enc_y[ENC_W-1]}}, in_data.enc_y};
		ax_full = dx[ERR_W-1] ? (~dx + 1'b1) : dx;
		ay_full = dy[ERR_W-1] ? (~dy + 1'b1) : dy;

		f1_d.ax  = ax_full[MAG_W-1:0];
		f1_d.ay  = ay_full[MAG_W-1:0];
		f1_d.spd = (in_data.move_speed > SPEED_MAX) ? SPEED_MAX : in_data.move_speed;

		f1_d.flags.neg_x   = dx[ERR_W-1];
		f1_d.flags.neg_y   = dy[ERR_W-1];
		f1_d.flags.x_hi    = in_data.enc_x >= $signed({{(ENC_W-POS_W){1'b0}}, cfg.x_limit});
		f1_d.flags.y_hi    = in_data.enc_y >= $signed({{(ENC_W-POS_W){1'b0}}, cfg.y_limit});
		f1_d.flags.x_lo    = in_data.enc_x[ENC_W-1] || (in_data.enc_x == '0);
		f1_d.flags.y_lo    = in_data.enc_y[ENC_W-1] || (in_data.enc_y == '0);
		f1_d.flags.arrived = (f1_d.ax <= {{(MAG_W-TOL_W){1'b0}}, cfg.tolerance})
			&& (f1_d.ay <= {{(MAG_W-TOL_W){1'b0}}, cfg.tolerance});
	end

	always_comb begin
		f2_d.sqx   = (2*MAG_W)'(f1_s1.ax) * (2*MAG_W)'(f1_s1.ax);
		f2_d.sqy   = (2*MAG_W)'(f1_s1.ay) * (2*MAG_W)'(f1_s1.ay);
		f2_d.nx    = NUM_W'(f1_s1.spd) * NUM_W'(f1_s1.ax);
		f2_d.ny    = NUM_W'(f1_s1.spd) * NUM_W'(f1_s1.ay);
		f2_d.flags = f1_s1.flags;
	end

	always_comb begin
		f3_d.rad   = RAD_W'(f2_s2.sqx) + RAD_W'(f2_s2.sqy);
		f3_d.nx    = f2_s2.nx;
		f3_d.ny    = f2_s2.ny;
		f3_d.flags = f2_s2.flags;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= in_valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) f1_s1 <= f1_d;
		if (adv2) f2_s2 <= f2_d;
		if (adv3) f3_s3 <= f3_d;
	end

	assign out_valid = vld_s3;
	assign out_data  = f3_s3;

endmodule

// ===== rtl/mtv_sqrt.sv =====
// Pipelined digit-by-digit integer square root of the squared distance.
module mtv_sqrt import mtv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sq_t  in_data,
	output logic out_valid,
	input  logic out_stall,
	output dv_t  out_data
);

	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		logic [NUM_W-1:0]  nx;
		logic [NUM_W-1:0]  ny;
		flags_t            flags;
	} sqst_t;

	sqst_t                  sq_s [SQRT_STAGES];
	logic [SQRT_STAGES-1:0] vld_s;
	logic [SQRT_STAGES-1:0] adv;
	sqst_t                  entry;

	always_comb begin
		entry.rad   = in_data.rad;
		entry.rem   = '0;
		entry.root  = '0;
		entry.nx    = in_data.nx;
		entry.ny    = in_data.ny;
		entry.flags = in_data.flags;
	end

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
		sqst_t cur, nxt;
		logic  prev_vld;

		if (k == 0) begin : g_first
			assign cur      = entry;
			assign prev_vld = in_valid;
		end else begin : g_next
			assign cur      = sq_s[k-1];
			assign prev_vld = vld_s[k-1];
		end

		if (k == SQRT_STAGES - 1) begin : g_last
			assign adv[k] = !vld_s[k] || !out_stall;
		end else begin : g_mid
			assign adv[k] = !vld_s[k] || adv[k+1];
		end

		// bring down two radicand bits, try root*4+1 against the remainder
		always_comb begin
			logic [REM_W-1:0] acc;
			logic [REM_W-1:0] trial;
			acc   = '0;
			trial = '0;
			nxt   = cur;
			for (int j = 0; j < SQRT_PER_STAGE; j++) begin
				if (k * SQRT_PER_STAGE + j < ROOT_W) begin
					acc     = {nxt.rem[REM_W-3:0], nxt.rad[RAD_W-1 -: 2]};
					nxt.rad = {nxt.rad[RAD_W-3:0], 2'b00};
					trial   = {{(REM_W-ROOT_W-2){1'b0}}, nxt.root, 2'b01};
					if (acc >= trial) begin
						nxt.rem  = acc - trial;
						nxt.root = {nxt.root[ROOT_W-2:0], 1'b1};
					end else begin
						nxt.rem  = acc;
						nxt.root = {nxt.root[ROOT_W-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv[k]) begin
				vld_s[k] <= prev_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k]) sq_s[k] <= nxt;
		end
	end

	assign in_stall       = !adv[0];
	assign out_valid      = vld_s[SQRT_STAGES-1];
	assign out_data.norm  = sq_s[SQRT_STAGES-1].root;
	assign out_data.nx    = sq_s[SQRT_STAGES-1].nx;
	assign out_data.ny    = sq_s[SQRT_STAGES-1].ny;
	assign out_data.flags = sq_s[SQRT_STAGES-1].flags;

endmodule

// ===== rtl/mtv_div.sv =====
// Pipelined restoring divider: both speed products over the distance in parallel.
module mtv_div import mtv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  dv_t  in_data,
	output logic out_valid,
	input  logic out_stall,
	output dq_t  out_data
);

	localparam int TRIAL_W = ROOT_W + QUO_W;

	typedef struct packed {
		logic [ROOT_W-1:0] norm;
		logic [NUM_W-1:0]  rx;
		logic [NUM_W-1:0]  ry;
		logic [QUO_W-1:0]  qx;
		logic [QUO_W-1:0]  qy;
		flags_t            flags;
	} dvst_t;

	dvst_t                 div_s [DIV_STAGES];
	logic [DIV_STAGES-1:0] vld_s;
	logic [DIV_STAGES-1:0] adv;
	dvst_t                 entry;

	always_comb begin
		entry.norm  = in_data.norm;
		entry.rx    = in_data.nx;
		entry.ry    = in_data.ny;
		entry.qx    = '0;
		entry.qy    = '0;
		entry.flags = in_data.flags;
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		dvst_t cur, nxt;
		logic  prev_vld;

		if (k == 0) begin : g_first
			assign cur      = entry;
			assign prev_vld = in_valid;
		end else begin : g_next
			assign cur      = div_s[k-1];
			assign prev_vld = vld_s[k-1];
		end

		if (k == DIV_STAGES - 1) begin : g_last
			assign adv[k] = !vld_s[k] || !out_stall;
		end else begin : g_mid
			assign adv[k] = !vld_s[k] || adv[k+1];
		end

		// quotient bits come out most significant first
		always_comb begin
			logic [TRIAL_W-1:0] trial;
			logic [TRIAL_W-1:0] remx;
			logic [TRIAL_W-1:0] remy;
			trial = '0;
			remx  = '0;
			remy  = '0;
			nxt   = cur;
			for (int j = 0; j < DIV_PER_STAGE; j++) begin
				if (k * DIV_PER_STAGE + j < QUO_W) begin
					trial = TRIAL_W'(nxt.norm) << (QUO_W - 1 - (k * DIV_PER_STAGE + j));
					remx  = TRIAL_W'(nxt.rx);
					remy  = TRIAL_W'(nxt.ry);
					if (remx >= trial) begin
						nxt.rx = NUM_W'(remx - trial);
						nxt.qx = {nxt.qx[QUO_W-2:0], 1'b1};
					end else begin
						nxt.qx = {nxt.qx[QUO_W-2:0], 1'b0};
					end
					if (remy >= trial) begin
						nxt.ry = NUM_W'(remy - trial);
						nxt.qy = {nxt.qy[QUO_W-2:0], 1'b1};
					end else begin
						nxt.qy = {nxt.qy[QUO_W-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv[k]) begin
				vld_s[k] <= prev_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k]) div_s[k] <= nxt;
		end
	end

	assign in_stall       = !adv[0];
	assign out_valid      = vld_s[DIV_STAGES-1];
	assign out_data.qx    = div_s[DIV_STAGES-1].qx;
	assign out_data.qy    = div_s[DIV_STAGES-1].qy;
	assign out_data.flags = div_s[DIV_STAGES-1].flags;

endmodule

// ===== rtl/mtv_drive.sv =====
// Drive stage: apply sign, travel limits and arrival, hold the result register.
module mtv_drive import mtv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  dq_t  in_data,
	output logic out_valid,
	input  logic out_stall,
	output out_t out_data
);

	function automatic logic signed [DRV_W-1:0] axis_drive(
		input logic [QUO_W-1:0] q,
		input logic             neg,
		input logic             at_hi,
		input logic             at_lo,
		input logic             arr
	);
		logic signed [DRV_W-1:0] mag;
		logic                    blocked;
		mag     = $signed({{(DRV_W-QUO_W){1'b0}}, q});
		// drop a drive that pushes past the upper limit or below zero
		blocked = arr || (neg ? at_lo : at_hi);
		return blocked ? '0 : (neg ? -mag : mag);
	endfunction

	out_t drv_d, drv_s17;
	logic drv_vld_s17;
	logic adv;

	assign adv      = !drv_vld_s17 || !out_stall;
	assign in_stall = !adv;

	always_comb begin
		drv_d.x_drive = axis_drive(in_data.qx, in_data.flags.neg_x, in_data.flags.x_hi,
			in_data.flags.x_lo, in_data.flags.arrived);
		drv_d.y_drive = axis_drive(in_data.qy, in_data.flags.neg_y, in_data.flags.y_hi,
			in_data.flags.y_lo, in_data.flags.arrived);
		drv_d.arrived = in_data.flags.arrived;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_vld_s17 <= 1'b0;
		end else if (adv) begin
			drv_vld_s17 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) drv_s17 <= drv_d;
	end

	assign out_valid = drv_vld_s17;
	assign out_data  = drv_s17;

endmodule

// ===== rtl/two_axis_move_to_velocity.sv =====
// Top level: configuration registers and the seventeen-stage velocity pipeline.
//
// One request per clock is taken while nothing stalls, and each gives exactly one result. It
// passes three front-end stages (errors, squares, sum), nine square-root stages retiring up
// to two root bits each, four divider stages retiring up to two quotient bits each for both
// axes at once, and the drive/output register. Stalls ripple back stage by stage, so empty
// stages keep filling while a result waits to be taken.
// Limits and tolerance are sampled as a request enters; write them only when idle.
module two_axis_move_to_velocity import mtv_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_t                  out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg_q;

	logic fr_valid, fr_stall;
	sq_t  fr_data;
	logic sr_valid, sr_stall;
	dv_t  sr_data;
	logic dv_valid, dv_stall;
	dq_t  dv_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_limit   <= 15'd32767;
			cfg_q.y_limit   <= 15'd32767;
			cfg_q.tolerance <= 10'd4;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_X_LIMIT:   cfg_q.x_limit   <= cfg_data[POS_W-1:0];
				REG_Y_LIMIT:   cfg_q.y_limit   <= cfg_data[POS_W-1:0];
				REG_TOLERANCE: cfg_q.tolerance <= cfg_data[TOL_W-1:0];
				default:       ;
			endcase
		end
	end

	mtv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (fr_valid),
		.out_stall (fr_stall),
		.out_data  (fr_data)
	);

	mtv_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_stall  (fr_stall),
		.in_data   (fr_data),
		.out_valid (sr_valid),
		.out_stall (sr_stall),
		.out_data  (sr_data)
	);

	mtv_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sr_valid),
		.in_stall  (sr_stall),
		.in_data   (sr_data),
		.out_valid (dv_valid),
		.out_stall (dv_stall),
		.out_data  (dv_data)
	);

	mtv_drive u_drive (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dv_valid),
		.in_stall  (dv_stall),
		.in_data   (dv_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ===== rtl/mtv_chk.sv =====
// Port checker for the move-to-velocity block, bound to the top level.
module mtv_chk import mtv_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input out_t out_data
);

	// arrival means both drives are off
	a_arrived_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.arrived |-> out_data.x_drive == '0 && out_data.y_drive == '0)
		else $error("drive non-zero on arrival");

	// a drive never exceeds full power either way
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.x_drive >= -8'sd100 && out_data.x_drive <= 8'sd100
			&& out_data.y_drive >= -8'sd100 && out_data.y_drive <= 8'sd100)
		else $error("drive out of range");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

endmodule

bind two_axis_move_to_velocity mtv_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

// ===== test/tb.sv =====
// Self-checking testbench for the two-axis move-to-velocity block.
`timescale 1ns / 100ps

module tb;
	import mtv_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_PER_PHASE = 75;
	localparam int PHASES = 7;

	typedef struct {
		in_t data;
		int  gap;
	} tick_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_t                   in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_t                  out_data;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// register copies as the block should hold them
	logic [POS_W-1:0] lim_x = 15'd32767;
	logic [POS_W-1:0] lim_y = 15'd32767;
	logic [TOL_W-1:0] tol = 10'd4;

	tick_t pending_ticks[$];
	out_t  expected_cmds[$];

	logic in_took = 1'b0;
	logic out_took = 1'b0;
	int   gap_left = -1;
	int   hold_left = 0;
	int   tx_idle = 0;
	int   rx_idle = 0;
	int   errors = 0;
	int   sent = 0;
	int   checked = 0;
	int   arrivals = 0;
	int   settings = 1;
	int   cycles = 0;

	two_axis_move_to_velocity uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Velocity command that one control tick should produce under the current registers.
	function automatic out_t predict_drive(in_t r);
		longint tx, ty, spd, ex, ey, dx, dy, ax, ay, sq, root, step, xd, yd;
		longint xl, yl, tl;
		out_t   o;
		tx  = longint'(r.target_x);
		ty  = longint'(r.target_y);
		spd = longint'(r.move_speed);
		ex  = longint'(r.enc_x);
		ey  = longint'(r.enc_y);
		xl  = longint'(lim_x);
		yl  = longint'(lim_y);
		tl  = longint'(tol);
		if (spd > 100)
			spd = 100;
		dx = tx - ex;
		dy = ty - ey;
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		o = '0;
		o.arrived = (ax <= tl) && (ay <= tl);
		if (!o.arrived) begin
			sq = ax * ax + ay * ay;
			root = 0;
			// build the floor root one bit at a time, top bit first
			for (int b = 17; b >= 0; b--) begin
				step = root + (longint'(1) << b);
				if (step * step <= sq)
					root = step;
			end
			xd = (spd * dx) / root;
			yd = (spd * dy) / root;
			if ((xd > 0 && ex >= xl) || (xd < 0 && ex <= 0))
				xd = 0;
			if ((yd > 0 && ey >= yl) || (yd < 0 && ey <= 0))
				yd = 0;
			o.x_drive = 8'(xd);
			o.y_drive = 8'(yd);
		end
		return o;
	endfunction

	function automatic int idle_draw(int mode);
		if (mode == 1)
			return $urandom_range(0, 15);
		if (mode == 2 && $urandom_range(0, 3) == 0)
			return $urandom_range(0, 15);
		return 0;
	endfunction

	function automatic in_t tick(int tx, int ty, int spd, int ex, int ey);
		in_t r;
		r.target_x   = POS_W'(tx);
		r.target_y   = POS_W'(ty);
		r.move_speed = SPD_W'(spd);
		r.enc_x      = ENC_W'(ex);
		r.enc_y      = ENC_W'(ey);
		return r;
	endfunction

	function automatic in_t random_tick();
		in_t r;
		int  pick;
		int  span;
		pick = $urandom_range(0, 9);
		span = int'(tol) + 3;
		r = tick($urandom_range(0, 32767), $urandom_range(0, 32767), $urandom_range(0, 100),
			$urandom_range(0, 32767), $urandom_range(0, 32767));
		if (pick < 3) begin
			r.move_speed = SPD_W'($urandom);
			r.enc_x      = ENC_W'($urandom);
			r.enc_y      = ENC_W'($urandom);
		end else if (pick < 6) begin
			// land close to the target so the arrival window is exercised
			r.enc_x = ENC_W'(int'(r.target_x) + int'($urandom_range(0, 2 * span)) - span);
			if (pick != 5)
				r.enc_y = ENC_W'(int'(r.target_y) + int'($urandom_range(0, 2 * span)) - span);
		end else if (pick < 8) begin
			r.enc_x = ENC_W'(int'(lim_x) + int'($urandom_range(0, 6)) - 3);
			r.enc_y = ENC_W'(int'(lim_y) + int'($urandom_range(0, 6)) - 3);
		end
		return r;
	endfunction

	task automatic push_tick(in_t r);
		tick_t t;
		t.data = r;
		t.gap  = idle_draw(tx_idle);
		pending_ticks.push_back(t);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_regs(int xl, int yl, int tl);
		write_reg(REG_X_LIMIT, CFG_DATA_W'(xl));
		write_reg(REG_Y_LIMIT, CFG_DATA_W'(yl));
		write_reg(REG_TOLERANCE, CFG_DATA_W'(tl));
		lim_x = POS_W'(xl);
		lim_y = POS_W'(yl);
		tol   = TOL_W'(tl);
		settings++;
	endtask

	// Hold until every request is in and every command is out, then let the pipe settle.
	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_ticks.size() != 0 || in_valid || expected_cmds.size() != 0);
		repeat (20) @(posedge clk);
	endtask

	// request driver
	always @(negedge clk) begin
		tick_t cur;
		logic  go;
		go = 1'b0;
		if (!in_valid || in_took) begin
			if (pending_ticks.size() != 0) begin
				if (gap_left < 0)
					gap_left = pending_ticks[0].gap;
				if (gap_left == 0) begin
					cur = pending_ticks.pop_front();
					go = 1'b1;
					gap_left = -1;
				end else begin
					gap_left--;
				end
			end
			in_valid <= go;
			if (go)
				in_data <= cur.data;
		end
	end

	// result stall: hold off for a drawn number of cycles after each command taken
	always @(negedge clk) begin
		if (out_took)
			hold_left = idle_draw(rx_idle);
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		out_t want;
		in_took  <= arst_n && in_valid && !in_stall;
		out_took <= arst_n && out_valid && !out_stall;
		if (arst_n && in_valid && !in_stall) begin
			expected_cmds.push_back(predict_drive(in_data));
			sent++;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_cmds.size() == 0) begin
				$error("unexpected command: x_drive %0d y_drive %0d arrived %0b",
					out_data.x_drive, out_data.y_drive, out_data.arrived);
				errors++;
			end else begin
				want = expected_cmds.pop_front();
				checked++;
				if (want.arrived)
					arrivals++;
				if (out_data.x_drive !== want.x_drive) begin
					$error("x_drive: expected %0d, actual %0d", want.x_drive, out_data.x_drive);
					errors++;
				end
				if (out_data.y_drive !== want.y_drive) begin
					$error("y_drive: expected %0d, actual %0d", want.y_drive, out_data.y_drive);
					errors++;
				end
				if (out_data.arrived !== want.arrived) begin
					$error("arrived: expected %0b, actual %0b", want.arrived, out_data.arrived);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d commands outstanding", cycles,
				expected_cmds.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int ph = 0; ph < PHASES; ph++) begin
			tx_idle = ph % 3;
			rx_idle = (ph + 1) % 3;
			case (ph)
				0: begin
					// reset values stand
				end
				1: set_regs(0, 0, 0);
				2: set_regs(32767, 32767, 1023);
				3: set_regs(100, 200, 4);
				5: set_regs(32767, 0, 1);
				default: set_regs($urandom_range(0, 32767), $urandom_range(0, 32767),
					$urandom_range(0, 40));
			endcase

			if (ph == 0) begin
				push_tick(tick(1000, 1000, 50, 1000, 1000));
				push_tick(tick(1004, 996, 50, 1000, 1000));
				push_tick(tick(1005, 1000, 50, 1000, 1000));
				push_tick(tick(1000, 995, 50, 1000, 1000));
				push_tick(tick(2000, 3000, 0, 1000, 1000));
				push_tick(tick(2000, 3000, 100, 1000, 1000));
				push_tick(tick(2000, 3000, 101, 1000, 1000));
				push_tick(tick(2000, 3000, 127, 1000, 1000));
				push_tick(tick(32767, 32767, 100, -32768, -32768));
				push_tick(tick(0, 0, 100, 32767, 32767));
				push_tick(tick(0, 32767, 100, 32767, -32768));
				push_tick(tick(32767, 0, 100, 0, 0));
				push_tick(tick(500, 0, 77, -100, 0));
				push_tick(tick(0, 0, 100, -4, -4));
				push_tick(tick(0, 0, 100, -5, 0));
				push_tick(tick(3, 4, 100, 0, 0));
				push_tick(tick(10, 10, 100, 3, 7));
				push_tick(tick(0, 0, 1, 32767, 1));
			end
			if (ph == 3) begin
				// drive into and away from the upper limits
				push_tick(tick(300, 50, 100, 100, 50));
				push_tick(tick(300, 50, 100, 99, 50));
				push_tick(tick(0, 1000, 100, 0, 200));
				push_tick(tick(10, 100, 100, 150, 100));
				push_tick(tick(500, 100, 100, 150, 250));
			end
			repeat (RANDOM_PER_PHASE) push_tick(random_tick());
			wait_idle();
		end

		if (expected_cmds.size() != 0) begin
			$error("%0d commands never arrived", expected_cmds.size());
			errors++;
		end
		$display("%0d requests under %0d register settings, idle and stall patterns varied",
			sent, settings);
		$display("%0d commands checked, %0d of them at target", checked, arrivals);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
